// ===== hw/rtl/pecs_pkg.sv =====
// Shared types, widths, register indexes and saturation helpers for the collision step block.
package pecs_pkg;

    localparam int POS_W = 20;
    localparam int VEL_W = 20;

    // shared multiplier: 42 x 21 signed, done as two partial products
    localparam int MUL_A_W = 42;
    localparam int MUL_B_W = 21;
    localparam int MUL_P_W = 63;

    // shared divider: signed dividend, unsigned divisor, 22 quotient bits plus sign
    localparam int DIV_N_W = 63;
    localparam int DIV_D_W = 38;
    localparam int DIV_Q_W = 23;

    // velocity / 60: (|v| * RECIP_60) >> RECIP_SHIFT is exact for |v| <= 2^19
    localparam int RECIP_SHIFT = 25;
    localparam logic signed [MUL_B_W-1:0] RECIP_60 = 21'sd559241;

    localparam logic signed [VEL_W-1:0] VEL_MAX = 20'sd524287;
    localparam logic signed [VEL_W-1:0] VEL_MIN = -20'sd524288;

    localparam logic [2:0] CFG_WINDOW_WIDTH   = 3'd0;
    localparam logic [2:0] CFG_WINDOW_HEIGHT  = 3'd1;
    localparam logic [2:0] CFG_SPRITE_WIDTH   = 3'd2;
    localparam logic [2:0] CFG_SPRITE_HEIGHT  = 3'd3;
    localparam logic [2:0] CFG_PARTICLE_COUNT = 3'd4;

    typedef struct packed {
        logic [POS_W-1:0]        pos_x;
        logic [POS_W-1:0]        pos_y;
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
    } particle_t;

    function automatic logic signed [VEL_W-1:0] neg20(input logic signed [VEL_W-1:0] v);
        logic signed [VEL_W-1:0] r;
        if (v == VEL_MIN)
            r = VEL_MAX;
        else
            r = -v;
        return r;
    endfunction

    // v + q or v - q, saturated to the signed 20-bit range
    function automatic logic signed [VEL_W-1:0] sat_addsub(
        input logic signed [VEL_W-1:0]   v,
        input logic signed [DIV_Q_W-1:0] q,
        input logic                      add
    );
        logic signed [23:0] ve;
        logic signed [23:0] qe;
        logic signed [23:0] s;
        logic signed [VEL_W-1:0] r;
        ve = $signed({{4{v[VEL_W-1]}}, v});
        qe = $signed({q[DIV_Q_W-1], q});
        s  = add ? (ve + qe) : (ve - qe);
        if (s > $signed({{4{1'b0}}, VEL_MAX}))
            r = VEL_MAX;
        else if (s < $signed({{4{1'b1}}, VEL_MIN}))
            r = VEL_MIN;
        else
            r = s[VEL_W-1:0];
        return r;
    endfunction

    // position plus step, held inside [0, win*256-1]
    function automatic logic [POS_W-1:0] adv_pos(
        input logic [POS_W-1:0]          pos,
        input logic signed [DIV_Q_W-1:0] q,
        input logic [11:0]               win
    );
        logic signed [23:0] s;
        logic [POS_W-1:0]   top;
        logic [POS_W-1:0]   r;
        s   = $signed({4'b0, pos}) + $signed({q[DIV_Q_W-1], q});
        top = (win == 12'd0) ? '0 : {win - 12'd1, 8'hFF};
        if (s < 24'sd0)
            r = '0;
        else if (s > $signed({4'b0, top}))
            r = top;
        else
            r = s[POS_W-1:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/pecs_mul.sv =====
// Shared signed multiplier: 42 x 21 bits, high partial product registered first, then the low one added.
module pecs_mul
    import pecs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic                      done,
    output logic signed [MUL_P_W-1:0] prod
);

    logic                      stage_reg;
    logic                      done_reg;
    logic signed [41:0]        hi_reg;
    logic [20:0]               lo_reg;
    logic signed [MUL_B_W-1:0] b_reg;
    logic signed [MUL_P_W-1:0] prod_reg;

    logic signed [41:0]        hi_prod;
    logic signed [42:0]        lo_prod;
    logic signed [MUL_P_W-1:0] prod_next;

    assign hi_prod   = $signed(a[41:21]) * b;
    assign lo_prod   = $signed({1'b0, lo_reg}) * b_reg;
    assign prod_next = $signed({hi_reg, 21'b0}) + $signed({{20{lo_prod[42]}}, lo_prod});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= start;
            done_reg  <= stage_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hi_reg <= hi_prod;
            lo_reg <= a[20:0];
            b_reg  <= b;
        end
        if (stage_reg)
            prod_reg <= prod_next;
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// ===== hw/rtl/pecs_div.sv =====
// Shared restoring divider: one quotient bit per cycle, truncation toward zero.
module pecs_div
    import pecs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0]        divisor,
    output logic                      done,
    output logic signed [DIV_Q_W-1:0] quot
);

    localparam int QBITS = DIV_Q_W - 1;
    localparam int SH_W  = DIV_D_W + QBITS - 1;

    logic                busy_reg;
    logic                done_reg;
    logic [4:0]          cnt_reg;
    logic [DIV_N_W-1:0]  rem_reg;
    logic [SH_W-1:0]     dsh_reg;
    logic [QBITS-1:0]    q_reg;
    logic                neg_reg;

    logic [DIV_N_W-1:0]  dsh_ext;
    logic                fits;

    assign dsh_ext = {{(DIV_N_W - SH_W){1'b0}}, dsh_reg};
    assign fits    = rem_reg >= dsh_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(QBITS - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[DIV_N_W-1] ? DIV_N_W'(-dividend) : DIV_N_W'(dividend);
            dsh_reg <= {divisor, {(QBITS - 1){1'b0}}};
            neg_reg <= dividend[DIV_N_W-1];
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_reg <= rem_reg - dsh_ext;
            q_reg   <= {q_reg[QBITS-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});

endmodule

// ===== hw/rtl/particle_elastic_collision_step.sv =====
// Collision step top level: particle table, tick sequencer, config registers and output register.
// A load is written into the table as it is accepted. After a tick is accepted, each particle is
// read, bounced off the walls, checked against every lower slot and written back; an overlapping
// pair runs six multiplies and two divides on the shared units. The advance then reads each
// particle, takes two reciprocal multiplies by 1/60 and waits while the output register is held
// by out_stall before it emits. Input stalls for the whole tick; one item at a time.
// Reset (async, active low) restores the register defaults; the particle table is not cleared.
module particle_elastic_collision_step
    import pecs_pkg::*;
#(
    parameter int MAX_PARTICLES = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    op,
    input  logic [3:0]              slot,
    input  logic [POS_W-1:0]        load_pos_x,
    input  logic [POS_W-1:0]        load_pos_y,
    input  logic signed [VEL_W-1:0] load_vel_x,
    input  logic signed [VEL_W-1:0] load_vel_y,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [3:0]              out_slot,
    output logic [POS_W-1:0]        out_pos_x,
    output logic [POS_W-1:0]        out_pos_y,
    output logic                    last,
    input  logic                    cfg_we,
    input  logic [2:0]              cfg_index,
    input  logic [11:0]             cfg_data
);

    localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
    localparam logic [7:0] MAX_P8 = 8'(MAX_PARTICLES);

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_RDJ   = 15'b000000000000010,
        S_LDJ   = 15'b000000000000100,
        S_RDL   = 15'b000000000001000,
        S_LDL   = 15'b000000000010000,
        S_CHK   = 15'b000000000100000,
        S_MULGO = 15'b000000001000000,
        S_MULW  = 15'b000000010000000,
        S_DIVGO = 15'b000000100000000,
        S_DIVW  = 15'b000001000000000,
        S_APPLY = 15'b000010000000000,
        S_WBJ   = 15'b000100000000000,
        S_ARD   = 15'b001000000000000,
        S_ALD   = 15'b010000000000000,
        S_EMIT  = 15'b100000000000000
    } state_t;

    typedef enum logic [2:0] {
        M_DXX = 3'd0,
        M_DYY = 3'd1,
        M_VX  = 3'd2,
        M_VY  = 3'd3,
        M_QX  = 3'd4,
        M_QY  = 3'd5,
        M_AX  = 3'd6,
        M_AY  = 3'd7
    } mstep_t;

    typedef enum logic [1:0] {
        D_CX = 2'd0,
        D_CY = 2'd1
    } dstep_t;

    state_t state_reg, state_next;
    mstep_t mstep_reg, mstep_next;
    dstep_t dstep_reg, dstep_next;

    logic [11:0] win_w_reg, win_h_reg;
    logic [9:0]  spr_w_reg, spr_h_reg;
    logic [4:0]  count_reg;

    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] l_reg, l_next;

    logic [POS_W-1:0]        pjx_reg, pjx_next, pjy_reg, pjy_next;
    logic signed [VEL_W-1:0] vjx_reg, vjx_next, vjy_reg, vjy_next;
    logic [POS_W-1:0]        plx_reg, plx_next, ply_reg, ply_next;
    logic signed [VEL_W-1:0] vlx_reg, vlx_next, vly_reg, vly_next;
    logic signed [20:0]      dx_reg, dx_next, dy_reg, dy_next;
    logic [DIV_D_W-1:0]      den_reg, den_next;
    logic signed [MUL_A_W-1:0] num_reg, num_next;
    logic signed [MUL_P_W-1:0] dvd_reg, dvd_next;
    logic signed [DIV_Q_W-1:0] qx_reg, qx_next, qy_reg, qy_next;

    logic              out_valid_reg, out_valid_next;
    logic [3:0]        out_slot_reg, out_slot_next;
    logic [POS_W-1:0]  out_pos_x_reg, out_pos_x_next, out_pos_y_reg, out_pos_y_next;
    logic              last_reg, last_next;

    particle_t         mem [MAX_PARTICLES];
    particle_t         rdata_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr, mem_raddr;
    particle_t         mem_wdata;

    logic                      mul_start, mul_done;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic                      div_start, div_done;
    logic signed [DIV_N_W-1:0] div_n;
    logic [DIV_D_W-1:0]        div_d;
    logic signed [DIV_Q_W-1:0] div_q;

    logic              accept;
    logic [6:0]        slot_ext;
    logic [7:0]        cnt_ext, n_sel;
    logic [7:0]        j_ext;
    logic [11:0]       spr_w_ext, spr_h_ext;
    logic [POS_W-1:0]  limx, limy;
    logic signed [20:0] dvx, dvy;
    logic [20:0]       adx, ady;
    logic [20:0]       reach;
    logic              l_wrap, j_wrap;
    logic signed [VEL_W-1:0] vx_a, vy_a;
    logic              out_free;
    logic [20:0]       vjx_mag, vjy_mag;
    logic [21:0]       adv_mag;

    pecs_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_p)
    );

    pecs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quot     (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign slot_ext  = {3'b0, slot};
    assign cnt_ext   = {3'b0, count_reg};
    assign n_sel     = (cnt_ext > MAX_P8) ? MAX_P8 : cnt_ext;
    assign j_ext     = 8'(j_reg);
    assign spr_w_ext = {2'b0, spr_w_reg};
    assign spr_h_ext = {2'b0, spr_h_reg};
    // right and bottom walls; zero when the sprite is as wide (high) as the window or wider
    assign limx = (win_w_reg > spr_w_ext) ? {win_w_reg - spr_w_ext, 8'h00} : '0;
    assign limy = (win_h_reg > spr_h_ext) ? {win_h_reg - spr_h_ext, 8'h00} : '0;
    assign dvx  = $signed({vjx_reg[VEL_W-1], vjx_reg}) - $signed({vlx_reg[VEL_W-1], vlx_reg});
    assign dvy  = $signed({vjy_reg[VEL_W-1], vjy_reg}) - $signed({vly_reg[VEL_W-1], vly_reg});
    assign adx  = dx_reg[20] ? 21'(-dx_reg) : 21'(dx_reg);
    assign ady  = dy_reg[20] ? 21'(-dy_reg) : 21'(dy_reg);
    assign reach = {3'b0, spr_w_reg, 8'h00};
    assign l_wrap = (l_reg + 1'b1) == j_reg;
    assign j_wrap = (j_reg + 1'b1) == n_reg;
    assign out_free = !out_valid_reg || !out_stall;
    // velocity magnitudes for the advance; the quotient takes the sign back afterwards
    assign vjx_mag = vjx_reg[VEL_W-1] ? (21'd0 - {1'b1, vjx_reg}) : {1'b0, vjx_reg};
    assign vjy_mag = vjy_reg[VEL_W-1] ? (21'd0 - {1'b1, vjy_reg}) : {1'b0, vjy_reg};
    assign adv_mag = mul_p[RECIP_SHIFT +: 22];
    assign div_n   = dvd_reg;
    assign div_d   = den_reg;

    // x velocity after the left and right wall tests, y likewise
    always_comb
    begin
        vx_a = (rdata_reg.pos_x == '0) ? neg20(rdata_reg.vel_x) : rdata_reg.vel_x;
        if (rdata_reg.pos_x >= limx)
            vx_a = neg20(vx_a);
        vy_a = (rdata_reg.pos_y == '0) ? neg20(rdata_reg.vel_y) : rdata_reg.vel_y;
        if (rdata_reg.pos_y >= limy)
            vy_a = neg20(vy_a);
    end

    always_comb
    begin
        unique case (mstep_reg)
            M_DXX:
            begin
                mul_a = MUL_A_W'(dx_reg);
                mul_b = dx_reg;
            end
            M_DYY:
            begin
                mul_a = MUL_A_W'(dy_reg);
                mul_b = dy_reg;
            end
            M_VX:
            begin
                mul_a = MUL_A_W'(dvx);
                mul_b = dx_reg;
            end
            M_VY:
            begin
                mul_a = MUL_A_W'(dvy);
                mul_b = dy_reg;
            end
            M_QX:
            begin
                mul_a = num_reg;
                mul_b = dx_reg;
            end
            M_QY:
            begin
                mul_a = num_reg;
                mul_b = dy_reg;
            end
            M_AX:
            begin
                mul_a = MUL_A_W'(vjx_mag);
                mul_b = RECIP_60;
            end
            M_AY:
            begin
                mul_a = MUL_A_W'(vjy_mag);
                mul_b = RECIP_60;
            end
            default:
            begin
                mul_a = num_reg;
                mul_b = dx_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        mstep_next = mstep_reg;
        dstep_next = dstep_reg;
        n_next     = n_reg;
        j_next     = j_reg;
        l_next     = l_reg;
        pjx_next   = pjx_reg;
        pjy_next   = pjy_reg;
        vjx_next   = vjx_reg;
        vjy_next   = vjy_reg;
        plx_next   = plx_reg;
        ply_next   = ply_reg;
        vlx_next   = vlx_reg;
        vly_next   = vly_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        den_next   = den_reg;
        num_next   = num_reg;
        dvd_next   = dvd_reg;
        qx_next    = qx_reg;
        qy_next    = qy_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_slot_next  = out_slot_reg;
        out_pos_x_next = out_pos_x_reg;
        out_pos_y_next = out_pos_y_reg;
        last_next      = last_reg;
        mem_we     = 1'b0;
        mem_waddr  = j_reg[IDX_W-1:0];
        mem_raddr  = j_reg[IDX_W-1:0];
        mem_wdata  = '{pos_x: pjx_reg, pos_y: pjy_reg, vel_x: vjx_reg, vel_y: vjy_reg};
        mul_start  = 1'b0;
        div_start  = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (!op)
                    begin
                        // slots past the table are dropped
                        mem_we    = (32'(slot) < MAX_PARTICLES);
                        mem_waddr = slot_ext[IDX_W-1:0];
                        mem_wdata = '{pos_x: load_pos_x, pos_y: load_pos_y,
                                      vel_x: load_vel_x, vel_y: load_vel_y};
                    end
                    else if (n_sel != 8'd0)
                    begin
                        n_next     = n_sel[CNT_W-1:0];
                        j_next     = '0;
                        state_next = S_RDJ;
                    end
                end
            end
            S_RDJ:
            begin
                state_next = S_LDJ;
            end
            S_LDJ:
            begin
                pjx_next = (rdata_reg.pos_x >= limx) ? limx : rdata_reg.pos_x;
                pjy_next = (rdata_reg.pos_y >= limy) ? limy : rdata_reg.pos_y;
                vjx_next = vx_a;
                vjy_next = vy_a;
                l_next   = '0;
                state_next = (j_reg == '0) ? S_WBJ : S_RDL;
            end
            S_RDL:
            begin
                mem_raddr  = l_reg[IDX_W-1:0];
                state_next = S_LDL;
            end
            S_LDL:
            begin
                plx_next = rdata_reg.pos_x;
                ply_next = rdata_reg.pos_y;
                vlx_next = rdata_reg.vel_x;
                vly_next = rdata_reg.vel_y;
                dx_next  = $signed({1'b0, pjx_reg}) - $signed({1'b0, rdata_reg.pos_x});
                dy_next  = $signed({1'b0, pjy_reg}) - $signed({1'b0, rdata_reg.pos_y});
                state_next = S_CHK;
            end
            S_CHK:
            begin
                // overlap on both axes, and coincident centers skip the exchange
                if (adx <= reach && ady <= reach && (dx_reg != '0 || dy_reg != '0))
                begin
                    mstep_next = M_DXX;
                    state_next = S_MULGO;
                end
                else
                begin
                    l_next     = l_reg + 1'b1;
                    state_next = l_wrap ? S_WBJ : S_RDL;
                end
            end
            S_MULGO:
            begin
                mul_start  = 1'b1;
                state_next = S_MULW;
            end
            S_MULW:
            begin
                if (mul_done)
                begin
                    unique case (mstep_reg)
                        M_DXX:
                        begin
                            den_next   = mul_p[DIV_D_W-1:0];
                            mstep_next = M_DYY;
                            state_next = S_MULGO;
                        end
                        M_DYY:
                        begin
                            den_next   = den_reg + mul_p[DIV_D_W-1:0];
                            mstep_next = M_VX;
                            state_next = S_MULGO;
                        end
                        M_VX:
                        begin
                            num_next   = mul_p[MUL_A_W-1:0];
                            mstep_next = M_VY;
                            state_next = S_MULGO;
                        end
                        M_VY:
                        begin
                            num_next   = num_reg + mul_p[MUL_A_W-1:0];
                            mstep_next = M_QX;
                            state_next = S_MULGO;
                        end
                        M_QX:
                        begin
                            dvd_next   = mul_p;
                            dstep_next = D_CX;
                            state_next = S_DIVGO;
                        end
                        M_QY:
                        begin
                            dvd_next   = mul_p;
                            dstep_next = D_CY;
                            state_next = S_DIVGO;
                        end
                        M_AX:
                        begin
                            qx_next    = vjx_reg[VEL_W-1] ? -$signed({1'b0, adv_mag})
                                                          : $signed({1'b0, adv_mag});
                            mstep_next = M_AY;
                            state_next = S_MULGO;
                        end
                        M_AY:
                        begin
                            qy_next    = vjy_reg[VEL_W-1] ? -$signed({1'b0, adv_mag})
                                                          : $signed({1'b0, adv_mag});
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    unique case (dstep_reg)
                        D_CX:
                        begin
                            qx_next    = div_q;
                            mstep_next = M_QY;
                            state_next = S_MULGO;
                        end
                        D_CY:
                        begin
                            qy_next    = div_q;
                            state_next = S_APPLY;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_APPLY:
            begin
                vjx_next  = sat_addsub(vjx_reg, qx_reg, 1'b0);
                vjy_next  = sat_addsub(vjy_reg, qy_reg, 1'b0);
                mem_we    = 1'b1;
                mem_waddr = l_reg[IDX_W-1:0];
                mem_wdata = '{pos_x: plx_reg, pos_y: ply_reg,
                              vel_x: sat_addsub(vlx_reg, qx_reg, 1'b1),
                              vel_y: sat_addsub(vly_reg, qy_reg, 1'b1)};
                l_next     = l_reg + 1'b1;
                state_next = l_wrap ? S_WBJ : S_RDL;
            end
            S_WBJ:
            begin
                mem_we = 1'b1;
                if (j_wrap)
                begin
                    j_next     = '0;
                    state_next = S_ARD;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_RDJ;
                end
            end
            S_ARD:
            begin
                state_next = S_ALD;
            end
            S_ALD:
            begin
                pjx_next   = rdata_reg.pos_x;
                pjy_next   = rdata_reg.pos_y;
                vjx_next   = rdata_reg.vel_x;
                vjy_next   = rdata_reg.vel_y;
                mstep_next = M_AX;
                state_next = S_MULGO;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = '{pos_x: adv_pos(pjx_reg, qx_reg, win_w_reg),
                                  pos_y: adv_pos(pjy_reg, qy_reg, win_h_reg),
                                  vel_x: vjx_reg, vel_y: vjy_reg};
                    out_valid_next = 1'b1;
                    out_slot_next  = j_ext[3:0];
                    out_pos_x_next = adv_pos(pjx_reg, qx_reg, win_w_reg);
                    out_pos_y_next = adv_pos(pjy_reg, qy_reg, win_h_reg);
                    last_next      = j_wrap;
                    j_next         = j_reg + 1'b1;
                    state_next     = j_wrap ? S_IDLE : S_ARD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mstep_reg     <= M_DXX;
            dstep_reg     <= D_CX;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            j_reg         <= '0;
            l_reg         <= '0;
            win_w_reg     <= 12'd640;
            win_h_reg     <= 12'd480;
            spr_w_reg     <= 10'd32;
            spr_h_reg     <= 10'd32;
            count_reg     <= 5'd16;
        end
        else
        begin
            state_reg     <= state_next;
            mstep_reg     <= mstep_next;
            dstep_reg     <= dstep_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            j_reg         <= j_next;
            l_reg         <= l_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WINDOW_WIDTH:   win_w_reg <= cfg_data;
                    CFG_WINDOW_HEIGHT:  win_h_reg <= cfg_data;
                    CFG_SPRITE_WIDTH:   spr_w_reg <= cfg_data[9:0];
                    CFG_SPRITE_HEIGHT:  spr_h_reg <= cfg_data[9:0];
                    CFG_PARTICLE_COUNT: count_reg <= cfg_data[4:0];
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pjx_reg       <= pjx_next;
        pjy_reg       <= pjy_next;
        vjx_reg       <= vjx_next;
        vjy_reg       <= vjy_next;
        plx_reg       <= plx_next;
        ply_reg       <= ply_next;
        vlx_reg       <= vlx_next;
        vly_reg       <= vly_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        den_reg       <= den_next;
        num_reg       <= num_next;
        dvd_reg       <= dvd_next;
        qx_reg        <= qx_next;
        qy_reg        <= qy_next;
        out_slot_reg  <= out_slot_next;
        out_pos_x_reg <= out_pos_x_next;
        out_pos_y_reg <= out_pos_y_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_slot  = out_slot_reg;
    assign out_pos_x = out_pos_x_reg;
    assign out_pos_y = out_pos_y_reg;
    assign last      = last_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the particle collision step: directed table, register corner cases, then random traffic.
`timescale 1ns / 1ps

module tb_top;
    import pecs_pkg::*;

    localparam int NPART = 16;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        bit        op;
        bit [3:0]  slot;
        bit [19:0] px;
        bit [19:0] py;
        bit [19:0] vx;
        bit [19:0] vy;
    } stim_row_t;

    typedef struct {
        bit [3:0]  slot;
        bit [19:0] px;
        bit [19:0] py;
        bit        last;
    } frame_pos_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic op = 1'b0;
    logic [3:0] slot = '0;
    logic [POS_W-1:0] load_pos_x = '0;
    logic [POS_W-1:0] load_pos_y = '0;
    logic signed [VEL_W-1:0] load_vel_x = '0;
    logic signed [VEL_W-1:0] load_vel_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [3:0] out_slot;
    logic [POS_W-1:0] out_pos_x;
    logic [POS_W-1:0] out_pos_y;
    logic last;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [11:0] cfg_data = '0;

    particle_elastic_collision_step dut (.*);

    // predictor state
    bit [11:0] win_w, win_h;
    bit [9:0] spr_w, spr_h;
    bit [4:0] part_cnt;
    bit [19:0] tab_px[NPART];
    bit [19:0] tab_py[NPART];
    logic signed [19:0] tab_vx[NPART];
    logic signed [19:0] tab_vy[NPART];

    frame_pos_t pending_pos[$];
    int errors = 0;
    int n_loads = 0;
    int n_ticks = 0;
    int n_results = 0;
    int send_idle = 0;
    int rcv_idle = 0;
    int hold_off = 0;
    longint cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("particle_elastic_collision_step regression: fail");
            $finish;
        end
    end

    task automatic report(string what, longint want, longint got);
        errors++;
        $display("MISMATCH %s: expected %0d got %0d (t=%0t)", what, want, got, $realtime);
    endtask

    function automatic logic signed [19:0] sat_vel(longint v);
        if (v > 524287)
            return 20'sd524287;
        if (v < -524288)
            return -20'sd524288;
        return v[19:0];
    endfunction

    function automatic longint wall_lim(bit [11:0] w, bit [9:0] s);
        longint lim;
        lim = (longint'(w) - longint'(s)) * 256;
        return (lim < 0) ? 0 : lim;
    endfunction

    function automatic void bounce(ref bit [19:0] p, ref logic signed [19:0] v, input longint lim);
        if (p == 0)
            v = sat_vel(-longint'(v));
        if (longint'(p) >= lim)
        begin
            p = lim[19:0];
            v = sat_vel(-longint'(v));
        end
    endfunction

    function automatic void exchange(int j, int l);
        longint dx, dy, reach, den, num, qx, qy;
        dx = longint'(tab_px[j]) - longint'(tab_px[l]);
        dy = longint'(tab_py[j]) - longint'(tab_py[l]);
        reach = longint'(spr_w) * 256;
        if ((dx < 0 ? -dx : dx) > reach || (dy < 0 ? -dy : dy) > reach)
            return;
        den = dx * dx + dy * dy;
        if (den == 0)
            return;
        num = (longint'(tab_vx[j]) - longint'(tab_vx[l])) * dx
            + (longint'(tab_vy[j]) - longint'(tab_vy[l])) * dy;
        qx = (num * dx) / den;
        qy = (num * dy) / den;
        tab_vx[j] = sat_vel(longint'(tab_vx[j]) - qx);
        tab_vy[j] = sat_vel(longint'(tab_vy[j]) - qy);
        tab_vx[l] = sat_vel(longint'(tab_vx[l]) + qx);
        tab_vy[l] = sat_vel(longint'(tab_vy[l]) + qy);
    endfunction

    function automatic bit [19:0] step_pos(bit [19:0] p, logic signed [19:0] v, bit [11:0] w);
        longint top, np;
        top = longint'(w) * 256 - 1;
        if (top < 0)
            top = 0;
        np = longint'(p) + longint'(v) / 60;
        if (np < 0)
            np = 0;
        if (np > top)
            np = top;
        return np[19:0];
    endfunction

    function automatic void predict_frame();
        int n;
        longint limx, limy;
        frame_pos_t r;
        n = (part_cnt > NPART) ? NPART : part_cnt;
        limx = wall_lim(win_w, spr_w);
        limy = wall_lim(win_h, spr_h);
        for (int j = 0; j < n; j++)
        begin
            bounce(tab_px[j], tab_vx[j], limx);
            bounce(tab_py[j], tab_vy[j], limy);
            for (int l = 0; l < j; l++)
                exchange(j, l);
        end
        for (int j = 0; j < n; j++)
        begin
            tab_px[j] = step_pos(tab_px[j], tab_vx[j], win_w);
            tab_py[j] = step_pos(tab_py[j], tab_vy[j], win_h);
            r.slot = j[3:0];
            r.px = tab_px[j];
            r.py = tab_py[j];
            r.last = (j == n - 1);
            pending_pos.push_back(r);
        end
    endfunction

    task automatic send_txn(stim_row_t t);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= t.op;
        slot <= t.slot;
        load_pos_x <= t.px;
        load_pos_y <= t.py;
        load_vel_x <= t.vx;
        load_vel_y <= t.vy;
        do
            @(posedge clk);
        while (in_stall);
        if (t.op)
        begin
            n_ticks++;
            predict_frame();
        end
        else
        begin
            n_loads++;
            tab_px[t.slot] = t.px;
            tab_py[t.slot] = t.py;
            tab_vx[t.slot] = t.vx;
            tab_vy[t.slot] = t.vy;
        end
    endtask

    // drain: a load or an empty tick leaves nothing to wait on, so allow its cycles too
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pos.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic cfg_write(bit [2:0] idx, bit [11:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        unique case (idx)
            CFG_WINDOW_WIDTH:   win_w = val;
            CFG_WINDOW_HEIGHT:  win_h = val;
            CFG_SPRITE_WIDTH:   spr_w = val[9:0];
            CFG_SPRITE_HEIGHT:  spr_h = val[9:0];
            CFG_PARTICLE_COUNT: part_cnt = val[4:0];
            default: ;
        endcase
    endtask

    task automatic cfg_all(bit [11:0] w, bit [11:0] h, bit [9:0] sw, bit [9:0] sh, bit [4:0] n);
        cfg_write(CFG_WINDOW_WIDTH, w);
        cfg_write(CFG_WINDOW_HEIGHT, h);
        cfg_write(CFG_SPRITE_WIDTH, {2'b0, sw});
        cfg_write(CFG_SPRITE_HEIGHT, {2'b0, sh});
        cfg_write(CFG_PARTICLE_COUNT, {7'b0, n});
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic stim_row_t tick_row();
        stim_row_t t;
        t.op = 1'b1;
        t.slot = 4'($urandom);
        t.px = 20'($urandom);
        t.py = 20'($urandom);
        t.vx = 20'($urandom);
        t.vy = 20'($urandom);
        return t;
    endfunction

    // clustered loads around a point in the window so that pairs overlap; noise uses the full field range
    function automatic stim_row_t load_row(bit noise, int cx, int cy);
        stim_row_t t;
        int vr;
        t.op = 1'b0;
        t.slot = 4'($urandom_range(NPART - 1));
        if (noise)
        begin
            t.px = 20'($urandom);
            t.py = 20'($urandom);
            t.vx = 20'($urandom);
            t.vy = 20'($urandom);
        end
        else
        begin
            t.px = 20'(cx + $urandom_range(spr_w * 256 + 255));
            t.py = 20'(cy + $urandom_range(spr_w * 256 + 255));
            vr = $urandom_range(1) ? 524287 : $urandom_range(60000);
            t.vx = 20'($urandom_range(2 * vr) - vr);
            t.vy = 20'($urandom_range(2 * vr) - vr);
        end
        return t;
    endfunction

    task automatic random_phase(int items, bit squeeze);
        int cx, cy;
        cx = $urandom_range(win_w) * 256;
        cy = $urandom_range(win_h) * 256;
        for (int i = 0; i < items; i++)
        begin
            int r;
            r = $urandom_range(99);
            if (squeeze && i == items / 2)
            begin
                hold_off = 3000;
                send_txn(tick_row());
                send_txn(load_row(1'b0, cx, cy));
            end
            else if (r < 18)
                send_txn(tick_row());
            else if (r < 30)
                send_txn(load_row(1'b1, cx, cy));
            else
                send_txn(load_row(1'b0, cx, cy));
        end
    endtask

    // output side: check against the oldest expectation, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (pending_pos.size() == 0)
                report("unexpected result, slot", -1, out_slot);
            else
            begin
                frame_pos_t e;
                e = pending_pos.pop_front();
                if (out_slot !== e.slot)
                    report("out_slot", e.slot, out_slot);
                if (out_pos_x !== e.px)
                    report("out_pos_x", e.px, out_pos_x);
                if (out_pos_y !== e.py)
                    report("out_pos_y", e.py, out_pos_y);
                if (last !== e.last)
                    report("last", e.last, last);
            end
        end
        if (hold_off > 0)
        begin
            hold_off--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rcv_idle);
    end

    stim_row_t directed[$];

    initial
    begin
        win_w = 640;
        win_h = 480;
        spr_w = 32;
        spr_h = 32;
        part_cnt = 16;
        for (int i = 0; i < NPART; i++)
        begin
            tab_px[i] = '0;
            tab_py[i] = '0;
            tab_vx[i] = '0;
            tab_vy[i] = '0;
        end

        // every slot gets loaded before the first tick
        directed.push_back('{1'b0, 4'd0, 20'h0, 20'h0, 20'h80000, 20'h7FFFF});
        directed.push_back('{1'b0, 4'd1, 20'hFFFFF, 20'hFFFFF, 20'h7FFFF, 20'h80000});
        directed.push_back('{1'b0, 4'd2, 20'd25600, 20'd25600, 20'd1000, 20'd0});
        directed.push_back('{1'b0, 4'd3, 20'd28160, 20'd25600, -20'sd1000, 20'd300});
        directed.push_back('{1'b0, 4'd4, 20'd51200, 20'd51200, 20'd500, 20'd500});
        directed.push_back('{1'b0, 4'd5, 20'd51200, 20'd51200, -20'sd700, 20'd0});
        for (int i = 6; i < NPART; i++)
            directed.push_back('{1'b0, i[3:0], 20'(i * 9000), 20'(i * 6500),
                                 20'(i * 3001 - 30000), 20'(20000 - i * 2900)});
        directed.push_back('{1'b1, 4'd0, 20'h0, 20'h0, 20'h0, 20'h0});
        directed.push_back('{1'b1, 4'd0, 20'h0, 20'h0, 20'h0, 20'h0});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_txn(directed[i]);
        wait_drained();

        // smallest window, largest sprite: both walls fire; count above the table size
        cfg_all(12'd1, 12'd1, 10'd1023, 10'd1023, 5'd31);
        send_txn(tick_row());
        wait_drained();
        cfg_all(12'd4095, 12'd4095, 10'd1, 10'd1, 5'd0);
        cfg_write(3'd5, 12'hFFF);
        cfg_write(3'd7, 12'h000);
        cfg_we <= 1'b0;
        send_txn(tick_row());
        wait_drained();
        cfg_all(12'd4095, 12'd4095, 10'd1, 10'd1, 5'd1);
        send_txn(tick_row());
        wait_drained();

        send_idle = 15;
        rcv_idle = 47;
        cfg_all(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
                10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)),
                5'($urandom_range(1, 16)));
        random_phase(34, 1'b0);
        wait_drained();

        send_idle = 47;
        rcv_idle = 15;
        cfg_all(12'd640, 12'd480, 10'd1023, 10'd32, 5'd16);
        random_phase(33, 1'b1);
        wait_drained();

        send_idle = 0;
        rcv_idle = 0;
        cfg_all(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
                10'($urandom_range(1, 1023)), 10'($urandom_range(1, 1023)),
                5'($urandom_range(1, 31)));
        random_phase(33, 1'b0);
        wait_drained();

        $display("covered %0d loads and %0d ticks, %0d position results checked",
                 n_loads, n_ticks, n_results);
        $display("wall, overlap, zero-distance and register extreme cases included");
        if (errors == 0 && pending_pos.size() == 0)
            $display("particle_elastic_collision_step regression: pass");
        else
            $display("particle_elastic_collision_step regression: fail");
        $finish;
    end

endmodule
